@@ rtl/assert_macros.svh @@
// Assertion macros shared by the look-at view matrix RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define LAVM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("look-at view matrix assertion failed");

// Condition that must hold on every clock edge outside reset.
`define LAVM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("look-at view matrix assertion failed");

`endif

@@ rtl/lavm_pkg.sv @@
// Types and constants shared by the look-at view matrix modules.
package lavm_pkg;

    typedef logic signed [15:0] t_s16;
    typedef logic signed [31:0] t_s32;
    typedef logic signed [49:0] t_s50;

    typedef t_s16 t_vec16 [3];
    typedef t_s32 t_vec32 [3];
    typedef t_s50 t_vec50 [3];

    // Control travelling with the basis request through the pipeline.
    typedef struct packed {
        logic valid;
        logic ident;
    } t_ctl;

    localparam int NORM_W     = 20;
    localparam int SIDE_W     = 3 * NORM_W + 3;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 16;

    localparam int PREP_LAT  = 4;
    localparam int UNIT_LAT  = 6 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int FIN_LAT   = 7;
    localparam int EYE_DLY   = PREP_LAT + UNIT_LAT;
    localparam int TOTAL_LAT = PREP_LAT + UNIT_LAT + FIN_LAT;

    localparam t_s16 ONE_Q14 = 16'sd16384;

endpackage

@@ rtl/lavm_prep.sv @@
// Front end: squared look length, up projection and the exact orthogonal up vector.
module lavm_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lavm_pkg::t_vec16   i_look,
    input  lavm_pkg::t_vec16   i_up,
    output lavm_pkg::t_ctl     o_ctl,
    output lavm_pkg::t_vec50   o_p,
    output lavm_pkg::t_vec50   o_nl
);

    logic [3:0]               r_vld;
    logic signed [31:0]       r1_ll [3];
    logic signed [31:0]       r1_ul [3];
    lavm_pkg::t_vec16         r1_l;
    lavm_pkg::t_vec16         r1_up;
    logic signed [33:0]       r2_sl;
    logic signed [33:0]       r2_d;
    lavm_pkg::t_vec16         r2_l;
    lavm_pkg::t_vec16         r2_up;
    lavm_pkg::t_vec50         r3_a;
    lavm_pkg::t_vec50         r3_b;
    logic                     r3_slz;
    lavm_pkg::t_vec16         r3_l;
    lavm_pkg::t_vec50         r4_p;
    lavm_pkg::t_vec50         r4_nl;
    logic                     r4_ident;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_ll[i] <= i_look[i] * i_look[i];
            r1_ul[i] <= i_up[i] * i_look[i];
        end
        r1_l  <= i_look;
        r1_up <= i_up;

        r2_sl <= 34'(r1_ll[0]) + 34'(r1_ll[1]) + 34'(r1_ll[2]);
        r2_d  <= 34'(r1_ul[0]) + 34'(r1_ul[1]) + 34'(r1_ul[2]);
        r2_l  <= r1_l;
        r2_up <= r1_up;

        for (int i = 0; i < 3; i++) begin
            r3_a[i] <= r2_sl * r2_up[i];
            r3_b[i] <= r2_d * r2_l[i];
        end
        r3_slz <= (r2_sl == '0);
        r3_l   <= r2_l;

        // The up vector is parallel to look exactly when both products agree.
        for (int i = 0; i < 3; i++) begin
            r4_p[i]  <= r3_a[i] - r3_b[i];
            r4_nl[i] <= -lavm_pkg::t_s50'(r3_l[i]);
        end
        r4_ident <= r3_slz || ((r3_a[0] == r3_b[0]) && (r3_a[1] == r3_b[1]) &&
                               (r3_a[2] == r3_b[2]));
    end

    assign o_ctl.valid = r_vld[3];
    assign o_ctl.ident = r4_ident;
    assign o_p         = r4_p;
    assign o_nl        = r4_nl;

endmodule

@@ rtl/lavm_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`include "assert_macros.svh"

module lavm_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [41:0]                   i_s,
    input  logic [lavm_pkg::SIDE_W-1:0]   i_side,
    output logic                          o_valid,
    output logic [30:0]                   o_root,
    output logic [lavm_pkg::SIDE_W-1:0]   o_side
);

    localparam int N = lavm_pkg::SQRT_STEPS;

    logic [N-1:0]                  r_vld;
    logic [31:0]                   r_rem  [N];
    logic [30:0]                   r_root [N];
    logic [61:0]                   r_x    [N];
    logic [lavm_pkg::SIDE_W-1:0]   r_side [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [31:0]                 rem_in;
        logic [30:0]                 root_in;
        logic [61:0]                 x_in;
        logic [lavm_pkg::SIDE_W-1:0] side_in;
        logic [33:0]                 cur;
        logic [33:0]                 trial;
        logic                        take;

        if (k == 0) begin : g_first
            // The radicand is the sum of squares scaled up by 2^20.
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = {i_s, 20'b0};
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign x_in    = r_x[k-1];
            assign side_in = r_side[k-1];
        end

        assign cur   = {rem_in, x_in[61:60]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= take ? 32'(cur - trial) : cur[31:0];
            r_root[k] <= {root_in[29:0], take};
            r_x[k]    <= {x_in[59:0], 2'b00};
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

    `LAVM_ASSERT_IMPL(a_isqrt_latency, i_clk, i_rst_n, o_valid, $past(i_valid, lavm_pkg::SQRT_STEPS))

endmodule

@@ rtl/lavm_div.sv @@
// Pipelined three-lane restoring divider giving the rounded unit components.
module lavm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [30:0]                   i_n,
    input  logic [lavm_pkg::SIDE_W-1:0]   i_side,
    output logic                          o_valid,
    output lavm_pkg::t_vec16              o_q
);

    localparam int N = lavm_pkg::DIV_STEPS;
    localparam int W = lavm_pkg::NORM_W;

    logic [N-1:0]      r_vld;
    logic [30:0]       r_n   [N];
    logic [30:0]       r_rem [N][3];
    logic [15:0]       r_q   [N][3];
    logic [2:0]        r_neg [N];
    logic              r_out_vld;
    lavm_pkg::t_vec16  r_out;
    lavm_pkg::t_vec16  n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[N-2:0], i_valid};
            r_out_vld <= r_vld[N-1];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [30:0] n_in;
        logic [30:0] rem_in [3];
        logic [15:0] q_in   [3];
        logic [2:0]  neg_in;

        if (k == 0) begin : g_first
            // Dividend is m * 2^25; its top part m * 2^9 is already below the divisor.
            assign n_in   = i_n;
            assign neg_in = i_side[lavm_pkg::SIDE_W-1 -: 3];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = {2'b00, i_side[i*W +: W], 9'b0};
                assign q_in[i]   = '0;
            end
        end else begin : g_next
            assign n_in   = r_n[k-1];
            assign neg_in = r_neg[k-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = r_rem[k-1][i];
                assign q_in[i]   = r_q[k-1][i];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if ({rem_in[i], 1'b0} >= {1'b0, n_in}) begin
                    r_rem[k][i] <= 31'({rem_in[i], 1'b0} - {1'b0, n_in});
                    r_q[k][i]   <= {q_in[i][14:0], 1'b1};
                end else begin
                    r_rem[k][i] <= {rem_in[i][29:0], 1'b0};
                    r_q[k][i]   <= {q_in[i][14:0], 1'b0};
                end
            end
            r_n[k]   <= n_in;
            r_neg[k] <= neg_in;
        end
    end

    // Round half up, clamp to one and restore the sign.
    always_comb begin
        logic [16:0] qr;
        logic [15:0] mg;
        for (int i = 0; i < 3; i++) begin
            qr = ({1'b0, r_q[N-1][i]} + 17'd1) >> 1;
            mg = (qr > 17'd16384) ? 16'd16384 : qr[15:0];
            n_out[i] = r_neg[N-1][i] ? -lavm_pkg::t_s16'(mg) : lavm_pkg::t_s16'(mg);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_q     = r_out;

endmodule

@@ rtl/lavm_unit.sv @@
// Unit vector pipeline: magnitude, normalising shift, sum of squares, root and divide.
module lavm_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lavm_pkg::t_vec50  i_a,
    output logic              o_valid,
    output lavm_pkg::t_vec16  o_q
);

    localparam int W = lavm_pkg::NORM_W;

    logic [5:0]    r_vld;
    logic [49:0]   r1_m [3];
    logic [49:0]   n2_m [3];
    logic [49:0]   r2_m [3];
    logic [49:0]   n3_m [3];
    logic [49:0]   r3_m [3];
    logic [49:0]   n4_m [3];
    logic [49:0]   r4_m [3];
    logic [W-1:0]  r5_m [3];
    logic [39:0]   r5_sq [3];
    logic [W-1:0]  r6_m [3];
    logic [41:0]   r6_s;
    logic [2:0]    r1_neg, r2_neg, r3_neg, r4_neg, r5_neg, r6_neg;
    logic          sq_valid;
    logic [30:0]   sq_root;
    logic [lavm_pkg::SIDE_W-1:0] sq_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // Leading-zero shift of the common magnitude, two shift steps per stage.
    always_comb begin
        logic [49:0] t [3];
        logic [49:0] o;
        o = r1_m[0] | r1_m[1] | r1_m[2];
        for (int i = 0; i < 3; i++) t[i] = (o[49:18] == '0) ? (r1_m[i] << 32) : r1_m[i];
        o = t[0] | t[1] | t[2];
        for (int i = 0; i < 3; i++) n2_m[i] = (o[49:34] == '0) ? (t[i] << 16) : t[i];
    end

    always_comb begin
        logic [49:0] t [3];
        logic [49:0] o;
        o = r2_m[0] | r2_m[1] | r2_m[2];
        for (int i = 0; i < 3; i++) t[i] = (o[49:42] == '0) ? (r2_m[i] << 8) : r2_m[i];
        o = t[0] | t[1] | t[2];
        for (int i = 0; i < 3; i++) n3_m[i] = (o[49:46] == '0) ? (t[i] << 4) : t[i];
    end

    always_comb begin
        logic [49:0] t [3];
        logic [49:0] o;
        o = r3_m[0] | r3_m[1] | r3_m[2];
        for (int i = 0; i < 3; i++) t[i] = (o[49:48] == '0) ? (r3_m[i] << 2) : r3_m[i];
        o = t[0] | t[1] | t[2];
        for (int i = 0; i < 3; i++) n4_m[i] = (o[49] == 1'b0) ? (t[i] << 1) : t[i];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_neg[i] <= i_a[i][49];
            r1_m[i]   <= i_a[i][49] ? -i_a[i] : i_a[i];
        end
        r2_m   <= n2_m;
        r2_neg <= r1_neg;
        r3_m   <= n3_m;
        r3_neg <= r2_neg;
        r4_m   <= n4_m;
        r4_neg <= r3_neg;

        // The top twenty bits give the largest component in [2^19, 2^20).
        for (int i = 0; i < 3; i++) begin
            r5_m[i]  <= r4_m[i][49:30];
            r5_sq[i] <= r4_m[i][49:30] * r4_m[i][49:30];
        end
        r5_neg <= r4_neg;

        r6_s   <= 42'(r5_sq[0]) + 42'(r5_sq[1]) + 42'(r5_sq[2]);
        r6_m   <= r5_m;
        r6_neg <= r5_neg;
    end

    lavm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[5]),
        .i_s     (r6_s),
        .i_side  ({r6_neg, r6_m[2], r6_m[1], r6_m[0]}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    lavm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_n     (sq_root),
        .i_side  (sq_side),
        .o_valid (o_valid),
        .o_q     (o_q)
    );

endmodule

@@ rtl/lavm_fin.sv @@
// Back end: identity select, right vector by cross product and the translation column.
`include "assert_macros.svh"

module lavm_fin (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lavm_pkg::t_ctl    i_ctl,
    input  lavm_pkg::t_vec16  i_v,
    input  lavm_pkg::t_vec16  i_w,
    input  lavm_pkg::t_vec32  i_eye,
    output logic              o_valid,
    output lavm_pkg::t_vec16  o_u,
    output lavm_pkg::t_vec16  o_v,
    output lavm_pkg::t_vec16  o_w,
    output lavm_pkg::t_vec32  o_t
);

    logic [6:0]          r_vld;
    lavm_pkg::t_vec16    n1_v, n1_w;
    lavm_pkg::t_vec16    r1_v, r1_w, r2_v, r2_w;
    lavm_pkg::t_vec32    r1_eye, r2_eye, r3_eye;
    logic signed [31:0]  r1_pa [3];
    logic signed [31:0]  r1_pb [3];
    logic signed [32:0]  r2_d  [3];
    lavm_pkg::t_vec16    n3_u;
    lavm_pkg::t_vec16    r3_rot [3];
    lavm_pkg::t_vec16    r4_rot [3];
    lavm_pkg::t_vec16    r5_rot [3];
    lavm_pkg::t_vec16    r6_rot [3];
    lavm_pkg::t_vec16    r7_rot [3];
    logic signed [47:0]  r4_pr [3][3];
    logic signed [49:0]  r5_acc [3];
    logic [2:0]          r6_neg;
    logic [36:0]         r6_rm [3];
    lavm_pkg::t_vec32    n7_t;
    lavm_pkg::t_vec32    r7_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_ctl.valid};
        end
    end

    // A degenerate basis falls back to the identity; its cross product is then (1, 0, 0).
    always_comb begin
        if (i_ctl.ident) begin
            n1_v[0] = '0;
            n1_v[1] = lavm_pkg::ONE_Q14;
            n1_v[2] = '0;
            n1_w[0] = '0;
            n1_w[1] = '0;
            n1_w[2] = lavm_pkg::ONE_Q14;
        end else begin
            n1_v = i_v;
            n1_w = i_w;
        end
    end

    always_comb begin
        logic [32:0] mg;
        logic [18:0] rm;
        logic [15:0] cl;
        for (int i = 0; i < 3; i++) begin
            mg = r2_d[i][32] ? -r2_d[i] : r2_d[i];
            rm = 19'((mg + 33'd8192) >> 14);
            cl = (rm > 19'd16384) ? 16'd16384 : rm[15:0];
            n3_u[i] = r2_d[i][32] ? -lavm_pkg::t_s16'(cl) : lavm_pkg::t_s16'(cl);
        end
    end

    always_comb begin
        logic [36:0] neg_rm;
        for (int i = 0; i < 3; i++) begin
            neg_rm = 37'd0 - r6_rm[i];
            if (r6_neg[i]) begin
                n7_t[i] = (r6_rm[i] > 37'h7FFFFFFF) ? 32'sh7FFFFFFF : r6_rm[i][31:0];
            end else begin
                n7_t[i] = (r6_rm[i] > 37'h80000000) ? 32'sh80000000 : neg_rm[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_v   <= n1_v;
        r1_w   <= n1_w;
        r1_eye <= i_eye;
        r1_pa[0] <= n1_v[1] * n1_w[2];
        r1_pb[0] <= n1_v[2] * n1_w[1];
        r1_pa[1] <= n1_v[2] * n1_w[0];
        r1_pb[1] <= n1_v[0] * n1_w[2];
        r1_pa[2] <= n1_v[0] * n1_w[1];
        r1_pb[2] <= n1_v[1] * n1_w[0];

        for (int i = 0; i < 3; i++) r2_d[i] <= 33'(r1_pa[i]) - 33'(r1_pb[i]);
        r2_v   <= r1_v;
        r2_w   <= r1_w;
        r2_eye <= r1_eye;

        r3_rot[0] <= n3_u;
        r3_rot[1] <= r2_v;
        r3_rot[2] <= r2_w;
        r3_eye    <= r2_eye;

        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) r4_pr[i][j] <= r3_rot[i][j] * r3_eye[j];
        end
        r4_rot <= r3_rot;

        for (int i = 0; i < 3; i++) begin
            r5_acc[i] <= 50'(r4_pr[i][0]) + 50'(r4_pr[i][1]) + 50'(r4_pr[i][2]);
        end
        r5_rot <= r4_rot;

        // Round the Q30 sum to Q16.16, half away from zero, on its magnitude.
        for (int i = 0; i < 3; i++) begin
            r6_neg[i] <= r5_acc[i][49];
            r6_rm[i]  <= 37'(((r5_acc[i][49] ? 50'(-r5_acc[i]) : 50'(r5_acc[i])) +
                              50'd8192) >> 14);
        end
        r6_rot <= r5_rot;

        r7_t   <= n7_t;
        r7_rot <= r6_rot;
    end

    assign o_valid = r_vld[6];
    assign o_u     = r7_rot[0];
    assign o_v     = r7_rot[1];
    assign o_w     = r7_rot[2];
    assign o_t     = r7_t;

    `LAVM_ASSERT_IMPL(a_fin_latency, i_clk, i_rst_n, o_valid, $past(i_ctl.valid, lavm_pkg::FIN_LAT))
    `LAVM_ASSERT_IMPL(a_fin_ident, i_clk, i_rst_n, o_valid && $past(i_ctl.ident, lavm_pkg::FIN_LAT), (o_u[0] == lavm_pkg::ONE_Q14) && (o_v[1] == lavm_pkg::ONE_Q14) && (o_w[2] == lavm_pkg::ONE_Q14))

endmodule

@@ rtl/look_at_view_matrix_unit.sv @@
// Top level of the fixed-point look-at view matrix pipeline.
//
// A request (look direction, up hint and eye position) is taken at every rising edge
// at which start is high; busy is tied low, so one request may be taken in every cycle.
// Each request gives exactly one result: the rotation rows right, true_up and back in
// Q1.14 and the saturated Q16.16 translation column, shown for one cycle with o_done.
// Results leave in request order. Each request passes through a 4-stage front end
// computing the exact orthogonal up vector, then two unit vector pipelines in parallel,
// each spending six stages on magnitude, normalising shift and sum of squares before
// the pipelined integer square root (31 stages) and the restoring divider (16 stages
// and an output register), and last a 7-stage back end for the cross product and the
// translation.
// Throughput is one request per cycle. The receiver cannot hold results off, and the
// pipeline never stalls, so nothing needs to be buffered on the output side.
// A synchronous reset (i_rst_n low) clears every valid bit, so no o_done follows from
// requests in flight at reset; data registers are not reset.
// A zero look vector, or an up hint that is zero or parallel to look, gives the identity
// rotation and a translation of minus the eye position.
`include "assert_macros.svh"

module look_at_view_matrix_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_look_x,
    input  logic [15:0] i_look_y,
    input  logic [15:0] i_look_z,
    input  logic [15:0] i_up_x,
    input  logic [15:0] i_up_y,
    input  logic [15:0] i_up_z,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    output logic        o_done,
    output logic [15:0] o_right_x,
    output logic [15:0] o_right_y,
    output logic [15:0] o_right_z,
    output logic [15:0] o_true_up_x,
    output logic [15:0] o_true_up_y,
    output logic [15:0] o_true_up_z,
    output logic [15:0] o_back_x,
    output logic [15:0] o_back_y,
    output logic [15:0] o_back_z,
    output logic [31:0] o_shift_x,
    output logic [31:0] o_shift_y,
    output logic [31:0] o_shift_z
);

    localparam int UL = lavm_pkg::UNIT_LAT;
    localparam int ED = lavm_pkg::EYE_DLY;

    lavm_pkg::t_vec16  look, up;
    lavm_pkg::t_ctl    prep_ctl;
    lavm_pkg::t_vec50  prep_p, prep_nl;
    logic              v_valid, w_valid;
    lavm_pkg::t_vec16  v_row, w_row;
    lavm_pkg::t_ctl    fin_ctl;
    lavm_pkg::t_vec32  fin_eye;
    lavm_pkg::t_vec16  fin_u, fin_v, fin_w;
    lavm_pkg::t_vec32  fin_t;
    logic [UL-1:0]     r_ident_dly;
    logic [95:0]       r_eye_dly [ED];

    // The pipeline never stalls, so a request is always taken.
    assign busy = 1'b0;

    assign look[0] = i_look_x;
    assign look[1] = i_look_y;
    assign look[2] = i_look_z;
    assign up[0]   = i_up_x;
    assign up[1]   = i_up_y;
    assign up[2]   = i_up_z;

    lavm_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_look  (look),
        .i_up    (up),
        .o_ctl   (prep_ctl),
        .o_p     (prep_p),
        .o_nl    (prep_nl)
    );

    // The back vector comes from the negated look, the true up from the orthogonal up.
    lavm_unit u_unit_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_ctl.valid),
        .i_a     (prep_nl),
        .o_valid (w_valid),
        .o_q     (w_row)
    );

    lavm_unit u_unit_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_ctl.valid),
        .i_a     (prep_p),
        .o_valid (v_valid),
        .o_q     (v_row)
    );

    // The degenerate flag waits beside the unit pipelines, the eye beside u_prep too.
    always_ff @(posedge i_clk) begin
        r_ident_dly  <= {r_ident_dly[UL-2:0], prep_ctl.ident};
        r_eye_dly[0] <= {i_eye_z, i_eye_y, i_eye_x};
        for (int k = 1; k < ED; k++) r_eye_dly[k] <= r_eye_dly[k-1];
    end

    assign fin_ctl.valid = v_valid && w_valid;
    assign fin_ctl.ident = r_ident_dly[UL-1];
    assign fin_eye[0]    = r_eye_dly[ED-1][31:0];
    assign fin_eye[1]    = r_eye_dly[ED-1][63:32];
    assign fin_eye[2]    = r_eye_dly[ED-1][95:64];

    lavm_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fin_ctl),
        .i_v     (v_row),
        .i_w     (w_row),
        .i_eye   (fin_eye),
        .o_valid (o_done),
        .o_u     (fin_u),
        .o_v     (fin_v),
        .o_w     (fin_w),
        .o_t     (fin_t)
    );

    assign o_right_x   = fin_u[0];
    assign o_right_y   = fin_u[1];
    assign o_right_z   = fin_u[2];
    assign o_true_up_x = fin_v[0];
    assign o_true_up_y = fin_v[1];
    assign o_true_up_z = fin_v[2];
    assign o_back_x    = fin_w[0];
    assign o_back_y    = fin_w[1];
    assign o_back_z    = fin_w[2];
    assign o_shift_x   = fin_t[0];
    assign o_shift_y   = fin_t[1];
    assign o_shift_z   = fin_t[2];

    `LAVM_ASSERT_IMPL(a_top_latency, i_clk, i_rst_n, o_done, $past(start, lavm_pkg::TOTAL_LAT))

endmodule
